[sv/sss_pkg.sv]
`default_nettype none

package sss_pkg;

   localparam logic [1:0] CMD_DEFINE = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_OPEN   = 2'd2;
   localparam logic [1:0] CMD_CLOSE  = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_DUPLICATE = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] symbol_id;
      logic [31:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_value;
      logic [8:0]  entry_count;
   } rsp_type;

endpackage

`default_nettype wire

[sv/scoped_symbol_stack.sv]
// Scoped symbol stack: a stack of bindings (symbol, value) and scope markers.
// Command channel: a transaction is accepted on a rising edge with start high
// and busy low; req_data carries the command, symbol_id and value_in.
// Result channel: rsp_valid is high for exactly one cycle with rsp_data
// (status, found_value, entry_count). The receiver cannot stall it.
// Each command gives exactly one result; busy is low again when it is issued.
// A full stack on define/open, or an empty stack on lookup/close, is answered
// straight from the idle state. Open scope writes its marker in the write state.
// Define, lookup and close walk the stack from the top through the single RAM
// read port, examining each entry in two steps (address, then registered data).
// A new command may be accepted in the cycle the result is shown.
// Reset empties the stack at once; the entry RAM needs no clearing since
// only entries below the stack top are ever read.

`default_nettype none

module scoped_symbol_stack #(
   parameter int STACK_DEPTH = 256,
   parameter int SYMBOL_BITS = 32,
   parameter int VALUE_BITS  = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire sss_pkg::req_type req_data,
   output logic                  rsp_valid,
   output sss_pkg::rsp_type      rsp_data
);

   localparam int AW    = $clog2(STACK_DEPTH);
   localparam int CW    = $clog2(STACK_DEPTH + 1);
   localparam int EW    = SYMBOL_BITS + VALUE_BITS + 1;
   localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ISSUE = 4'b0010,
      S_EVAL  = 4'b0100,
      S_WRITE = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           top_ff, top_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [1:0]              cmd_ff, cmd_in;
   logic [SYMBOL_BITS-1:0]  sym_ff, sym_in;
   logic [VALUE_BITS-1:0]   val_ff, val_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   sss_pkg::rsp_type        rsp_ff, rsp_in;

   logic [CW-1:0]           idx_m1;
   logic                    last_entry;
   logic                    ram_wr_en, ram_rd_en;
   logic [AW-1:0]           ram_wr_addr;
   logic [EW-1:0]           ram_wr_data, ram_rd_data;
   logic [SYMBOL_BITS-1:0]  ent_sym;
   logic [VALUE_BITS-1:0]   ent_val;
   logic                    ent_marker;
   logic                    ent_match;

   sss_ram #(
      .WIDTH (EW),
      .DEPTH (STACK_DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_m1[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign idx_m1     = idx_ff - CW'(1);
   assign last_entry = (idx_m1 == '0);
   assign ent_sym    = ram_rd_data[EW-1 -: SYMBOL_BITS];
   assign ent_val    = ram_rd_data[VALUE_BITS:1];
   assign ent_marker = ram_rd_data[0];
   assign ent_match  = (ent_sym == sym_ff);

   always_comb begin
      state_in     = state_ff;
      top_in       = top_ff;
      idx_in       = idx_ff;
      cmd_in       = cmd_ff;
      sym_in       = sym_ff;
      val_in       = val_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_wr_addr  = top_ff[AW-1:0];
      ram_wr_data  = {sym_ff, val_ff, 1'b0};

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in = req_data.command;
               sym_in = SYMBOL_BITS'(req_data.symbol_id);
               val_in = VALUE_BITS'(req_data.value_in);
               idx_in = top_ff;
               rsp_in.found_value = '0;
               rsp_in.status      = sss_pkg::ST_OK;
               unique case (req_data.command)
                  sss_pkg::CMD_DEFINE: begin
                     if (top_ff == FULL_COUNT) begin
                        rsp_in.status = sss_pkg::ST_FULL;
                        rsp_valid_in  = 1'b1;
                     end else if (top_ff == '0) begin
                        state_in = S_WRITE;
                     end else begin
                        state_in = S_ISSUE;
                     end
                  end
                  sss_pkg::CMD_LOOKUP: begin
                     if (top_ff == '0) begin
                        rsp_in.status = sss_pkg::ST_NOT_FOUND;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = S_ISSUE;
                     end
                  end
                  sss_pkg::CMD_OPEN: begin
                     if (top_ff == FULL_COUNT) begin
                        rsp_in.status = sss_pkg::ST_FULL;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = S_WRITE;
                     end
                  end
                  default: begin
                     if (top_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = S_ISSUE;
                     end
                  end
               endcase
            end
         end
         S_ISSUE: begin
            ram_rd_en = 1'b1;
            state_in  = S_EVAL;
         end
         S_EVAL: begin
            // The entry just read sits at index idx_ff - 1.
            state_in = S_ISSUE;
            unique case (cmd_ff)
               sss_pkg::CMD_DEFINE: begin
                  if (ent_marker) begin
                     state_in = S_WRITE;
                  end else if (ent_match) begin
                     rsp_in.status = sss_pkg::ST_DUPLICATE;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     idx_in = idx_m1;
                     if (last_entry) begin
                        state_in = S_WRITE;
                     end
                  end
               end
               sss_pkg::CMD_LOOKUP: begin
                  if (!ent_marker && ent_match) begin
                     rsp_in.status      = sss_pkg::ST_OK;
                     rsp_in.found_value = 32'(ent_val);
                     rsp_valid_in       = 1'b1;
                     state_in           = S_IDLE;
                  end else begin
                     idx_in = idx_m1;
                     if (last_entry) begin
                        rsp_in.status = sss_pkg::ST_NOT_FOUND;
                        rsp_valid_in  = 1'b1;
                        state_in      = S_IDLE;
                     end
                  end
               end
               sss_pkg::CMD_CLOSE: begin
                  idx_in = idx_m1;
                  if (ent_marker || last_entry) begin
                     top_in       = idx_m1;
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_WRITE: begin
            ram_wr_en = 1'b1;
            if (cmd_ff == sss_pkg::CMD_OPEN) begin
               ram_wr_data = {{SYMBOL_BITS{1'b0}}, {VALUE_BITS{1'b0}}, 1'b1};
            end
            top_in       = top_ff + CW'(1);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in.entry_count = 9'(top_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cmd_ff <= cmd_in;
      sym_ff <= sym_in;
      val_ff <= val_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result issued without a command in flight");

   a_top_bounded: assert property (@(posedge clock) disable iff (reset)
      top_ff <= FULL_COUNT)
      else $error("stack top beyond depth");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == sss_pkg::ST_FULL) |-> (top_ff == FULL_COUNT))
      else $error("full reported on a stack that is not full");

   a_found_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found_value != '0) |-> (rsp_data.status == sss_pkg::ST_OK))
      else $error("value returned with a failing status");

   a_top_moves_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && top_ff != $past(top_ff)) |-> rsp_valid)
      else $error("stack top changed without a result");
`endif

endmodule

`default_nettype wire

[sv/sss_ram.sv]
`default_nettype none

module sss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
